### rtl/sida_pkg.sv
package sida_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned IDX_W      = 4;
  // binary bits consumed by one double-dabble stage
  localparam int unsigned STAGE_BITS = 8;
  localparam int unsigned NUM_DABBLE = VALUE_W / STAGE_BITS;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] sida_bcd_t;

  // payload travelling down the conversion pipeline
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] bin;
    sida_bcd_t          bcd;
  } sida_conv_t;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_SIGN,
    SER_DIGIT
  } sida_ser_state_e;

  // one double-dabble step: correct every digit, then shift in one bit
  function automatic sida_bcd_t dabble_bit(sida_bcd_t bcd, logic b);
    sida_bcd_t                       adj;
    logic [NUM_DIGITS*DIGIT_W-1:0] flat;
    adj = bcd;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (adj[d] >= DABBLE_MIN) begin
        adj[d] = adj[d] + DABBLE_ADD;
      end
    end
    flat = adj;
    return sida_bcd_t'({flat[NUM_DIGITS*DIGIT_W-2:0], b});
  endfunction

endpackage

### rtl/sida_value_if.sv
interface sida_value_if;
  import sida_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/sida_char_if.sv
interface sida_char_if;
  import sida_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

### rtl/sida_abs_stage.sv
module sida_abs_stage
  import sida_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sida_conv_t         data_o
);

  logic       valid_q, valid_d;
  sida_conv_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_i && ready_o) begin
      valid_d     = 1'b1;
      data_d.neg  = value_i[VALUE_W-1];
      // unsigned negation, so the most negative value yields its true magnitude
      data_d.bin  = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
      data_d.bcd  = '0;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/sida_dabble_stage.sv
module sida_dabble_stage
  import sida_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  sida_conv_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output sida_conv_t data_o
);

  logic       valid_q, valid_d;
  sida_conv_t data_q, data_d;
  sida_bcd_t  bcd_w;

  assign ready_o = !valid_q || ready_i;

  // consume the top bits of the remaining binary, msb first
  always_comb begin
    bcd_w = data_i.bcd;
    for (int k = 0; k < STAGE_BITS; k++) begin
      bcd_w = dabble_bit(bcd_w, data_i.bin[VALUE_W-1-k]);
    end
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_i && ready_o) begin
      valid_d    = 1'b1;
      data_d.neg = data_i.neg;
      data_d.bin = data_i.bin << STAGE_BITS;
      data_d.bcd = bcd_w;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/sida_serial.sv
module sida_serial
  import sida_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sida_conv_t        data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_o
);

  sida_ser_state_e   state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  sida_bcd_t         bcd_q, bcd_d;
  logic [IDX_W-1:0]  msd_w;
  logic              out_xfer;
  logic              load;

  // most significant non-zero digit, zero keeps a single digit
  always_comb begin
    msd_w = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (data_i.bcd[d] != '0) begin
        msd_w = IDX_W'(d);
      end
    end
  end

  assign valid_o  = (state_q != SER_IDLE);
  assign out_xfer = valid_o && ready_i;
  assign ready_o  = (state_q == SER_IDLE) || (out_xfer && last_o);
  assign load     = valid_i && ready_o;

  // character on the output for the current state
  always_comb begin
    character_o = ASCII_MINUS;
    last_o      = 1'b0;
    case (state_q)
      SER_SIGN: begin
        character_o = ASCII_MINUS;
        last_o      = 1'b0;
      end
      SER_DIGIT: begin
        character_o = ASCII_ZERO + CHAR_W'(bcd_q[idx_q]);
        last_o      = (idx_q == '0);
      end
      default: begin
        character_o = ASCII_MINUS;
        last_o      = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    case (state_q)
      SER_SIGN: begin
        if (out_xfer) begin
          state_d = SER_DIGIT;
        end
      end
      SER_DIGIT: begin
        if (out_xfer) begin
          if (idx_q == '0) begin
            state_d = SER_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = SER_IDLE;
      end
    endcase
    if (load) begin
      state_d = data_i.neg ? SER_SIGN : SER_DIGIT;
      idx_d   = msd_w;
      bcd_d   = data_i.bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SER_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    bcd_q <= bcd_d;
  end

  a_sign_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SER_SIGN |-> character_o == ASCII_MINUS && !last_o)
    else $error("sign state must show a non-final minus");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SER_DIGIT |-> idx_q < IDX_W'(NUM_DIGITS))
    else $error("digit index out of range");

  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SER_SIGN && out_xfer |=> state_q == SER_DIGIT)
    else $error("minus must be followed by digits");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SER_DIGIT && out_xfer && idx_q != '0
    |=> state_q == SER_DIGIT && idx_q == $past(idx_q) - 1'b1)
    else $error("digit index must count down by one");

  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SER_IDLE && !(out_xfer && last_o) |-> !ready_o)
    else $error("new number taken before the text finished");

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text
//
// in_i : one transfer carries one two's complement value
// out_o: one transfer per character, most significant first; a negative value
//        opens with '-', there are no leading zeros, zero gives a single '0';
//        last marks the final character of each number
//
// path    : each number passes the magnitude stage, four double-dabble stages,
//           then the serialiser, each of them registered
// throughput: the serialiser sends one character per cycle while out_o.ready
//           is high; a number is 1 to 11 characters (digit count, plus one if
//           negative); the pipeline ahead buffers up to five further numbers
// reset   : all valid bits and the serialiser state clear at once, no sweep
// stall   : when out_o.ready is low the current character holds, the stages
//           fill up behind it and in_i.ready drops; nothing is lost or repeated
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sida_value_if.sink  in_i,
  sida_char_if.source out_o
);

  // stage k holds the item after k double-dabble stages
  logic       stg_valid [NUM_DABBLE+1];
  logic       stg_ready [NUM_DABBLE+1];
  sida_conv_t stg_data  [NUM_DABBLE+1];

  // sign and magnitude
  sida_abs_stage u_abs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .value_i (in_i.value),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // binary to bcd, a byte of the magnitude per stage
  for (genvar g = 0; g < NUM_DABBLE; g++) begin : g_dabble
    sida_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // one character per transfer
  sida_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[NUM_DABBLE]),
    .ready_o     (stg_ready[NUM_DABBLE]),
    .data_i      (stg_data[NUM_DABBLE]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

endmodule

### dv/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb
  import sida_pkg::*;
;

  // worst case is roughly 300 numbers of 11 characters, each character waiting
  // out the longest receiver stall, plus sender gaps; this is several times that
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // the first character only shows once a number has passed every stage, so allow margin
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned RADIX        = 10;

  // one character of a number's decimal text as it should leave the block
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic clk_i;
  logic rst_ni;

  sida_value_if value_if ();
  sida_char_if  char_if ();

  signed_int_to_decimal_ascii uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (value_if),
    .out_o  (char_if)
  );

  // characters still owed by the block, oldest first
  text_char_t  expected_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // sender burst shaping and receiver stall pattern
  bit          gaps_en     = 1'b1;
  bit          stalls_en   = 1'b1;
  int unsigned burst_left  = 0;
  logic [7:0]  stall_mask  = 8'hA5;
  int unsigned stall_phase = 0;

  always #5 clk_i = ~clk_i;

  // hard stop in case the block hangs or drops characters
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // decimal text of one value: optional sign, then digits with no leading zeros
  function automatic void render_decimal(logic [VALUE_W-1:0] word);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digit_chars [NUM_DIGITS];
    int                 n_digits;
    n_digits = 0;
    // negation in 32 bits also gives the right magnitude for the most negative value
    mag = word[VALUE_W-1] ? (~word + 1'b1) : word;
    do begin
      digit_chars[n_digits] = ASCII_ZERO + CHAR_W'(mag % RADIX);
      mag = mag / RADIX;
      n_digits++;
    end while (mag != 0);
    if (word[VALUE_W-1]) begin
      expected_chars.push_back(text_char_t'{ASCII_MINUS, 1'b0});
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      expected_chars.push_back(text_char_t'{digit_chars[i], (i == 0)});
    end
  endfunction

  // offers one value and returns at the edge where the transfer happens;
  // valid is left high so the next call can follow straight on
  task automatic send_value(logic [VALUE_W-1:0] word);
    int unsigned gap;
    if (gaps_en && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      value_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    if (gaps_en) begin
      burst_left--;
    end
    value_if.valid <= 1'b1;
    value_if.value <= word;
    do @(posedge clk_i); while (!value_if.ready);
    render_decimal(word);
  endtask

  // holds the sender off until every owed character has come out;
  // always moves on at least one edge so valid is only driven once per step
  task automatic wait_text_drained();
    value_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  // receiver: check every character transfer and drive ready on its own pattern
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && char_if.valid && char_if.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", char_if.character, 0);
      end else begin
        want = expected_chars.pop_front();
        if (char_if.character !== want.character) begin
          report_mismatch("character", char_if.character, want.character);
        end
        if (char_if.last !== want.last) begin
          report_mismatch("last", char_if.last, want.last);
        end
      end
    end
    // a new stall pattern at regular intervals, sometimes a long stall one
    stall_phase++;
    if (stall_phase % 64 == 0) begin
      stall_mask = ($urandom_range(0, 3) == 0) ? 8'h01 : (8'($urandom) | 8'h01);
    end
    char_if.ready <= !stalls_en || stall_mask[0];
    stall_mask = {stall_mask[0], stall_mask[7:1]};
  end

  // zero, single digits, decade edges, both ends of the range and the most
  // negative value, with a full drain in the middle
  task automatic test_extremes();
    int corner_values [20] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
      2147483647, -2147483647, int'(32'h8000_0000), 1000000000, -1000000000,
      999999999, -999999999, 1234567890, int'(32'h5555_5555), int'(32'hAAAA_AAAA)
    };
    gaps_en   = 1'b1;
    stalls_en = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_value(corner_values[i]);
      if (i == 9) begin
        wait_text_drained();
      end
    end
  endtask

  // random values spread evenly over digit counts and signs
  task automatic test_digit_counts(int unsigned n_items);
    longint unsigned p10;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int unsigned     n_digits;
    bit              neg;
    gaps_en   = 1'b1;
    stalls_en = 1'b1;
    repeat (n_items) begin
      n_digits = $urandom_range(1, NUM_DIGITS);
      neg      = $urandom_range(0, 1);
      p10 = 1;
      repeat (n_digits - 1) p10 *= RADIX;
      lo = (n_digits == 1) ? 0 : p10;
      hi = p10 * RADIX - 1;
      // ten-digit magnitudes stop at the ends of the 32-bit range
      if (neg && hi > 64'd2147483648) begin
        hi = 64'd2147483648;
      end else if (!neg && hi > 64'd2147483647) begin
        hi = 64'd2147483647;
      end
      mag = lo + $urandom_range(0, 32'(hi - lo));
      send_value(neg ? 32'(64'd0 - mag) : 32'(mag));
    end
  endtask

  // raw 32-bit words so every input bit is seen at both levels
  task automatic test_raw_words(int unsigned n_items);
    gaps_en   = 1'b1;
    stalls_en = 1'b1;
    repeat (n_items) begin
      send_value($urandom);
    end
  endtask

  // no sender gaps: short texts fill the pipeline, first with the receiver
  // always ready, then with it stalling so in_i.ready has to drop
  task automatic test_back_to_back(int unsigned n_items);
    logic [VALUE_W-1:0] word;
    gaps_en   = 1'b0;
    stalls_en = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        stalls_en = 1'b1;
      end
      word = $urandom;
      word = $signed(word) >>> $urandom_range(0, VALUE_W - 1);
      send_value(word);
    end
    wait_text_drained();
    gaps_en   = 1'b1;
    stalls_en = 1'b1;
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    value_if.valid = 1'b0;
    value_if.value = '0;
    char_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_digit_counts(150);
    test_raw_words(60);
    test_back_to_back(50);

    // all values sent: let the tail of the text out, then watch for strays
    wait_text_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii: match");
    end else begin
      $display("signed_int_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
